/* rtl/qtp_pkg.sv */
// ----------------------------------------------------------------------------
// qtp_pkg
// Shared types, widths and helpers for the quintic trajectory point block.
// ----------------------------------------------------------------------------
package qtp_pkg;

   // register map, index = paddr[3:2]
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam logic [1:0] REG_START    = 2'd0;
   localparam logic [1:0] REG_END      = 2'd1;
   localparam logic [1:0] REG_DURATION = 2'd2;

   localparam int TICK_W  = 31;
   localparam int TIME_W  = 32;
   localparam int POS_W   = 32;
   localparam int DERIV_W = 64;

   localparam int LIMB_W    = 32;
   localparam int PROD_W    = 2 * LIMB_W;
   localparam int NUM_LIMBS = 6;
   localparam int NUM_W     = NUM_LIMBS * LIMB_W;
   localparam int SQ_W      = 2 * TICK_W;
   localparam int P_W       = SQ_W + 6;

   localparam int T5_LIMBS   = 5;
   localparam int T5_W       = T5_LIMBS * LIMB_W;
   localparam int QUO_W      = 64;
   localparam int REM_W      = T5_W + QUO_W;
   localparam int SCALE_SHIFT = 32;

   localparam int LIMB_IDX_W = 3;
   localparam int PASS_W     = 2;
   localparam logic [LIMB_IDX_W-1:0] LAST_LIMB = LIMB_IDX_W'(T5_LIMBS - 1);
   localparam logic [PASS_W-1:0]     LAST_PASS = PASS_W'(3);

   localparam int LANES    = 3;
   localparam int LANE_POS = 0;
   localparam int LANE_VEL = 1;
   localparam int LANE_ACC = 2;

   localparam logic [LIMB_W-1:0] UNIT_GAIN = LIMB_W'(1);
   localparam logic [LIMB_W-1:0] VEL_GAIN  = LIMB_W'(30);
   localparam logic [LIMB_W-1:0] ACC_GAIN  = LIMB_W'(60);

   localparam logic [DERIV_W-1:0] POS_LIMIT = {1'b0, {(DERIV_W-1){1'b1}}};
   localparam logic [DERIV_W-1:0] NEG_LIMIT = {1'b1, {(DERIV_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CFG_IDLE,
      CFG_LOAD,
      CFG_MUL
   } cfg_state_type;

   typedef struct packed {
      logic                busy;
      logic                dneg;
      logic [LIMB_W-1:0]   dmag;
      logic [POS_W-1:0]    start_pos;
      logic [POS_W-1:0]    end_pos;
      logic [TICK_W-1:0]   duration;
      logic [T5_W-1:0]     t5;
   } cfg_type;

   typedef struct packed {
      logic              below;
      logic              above;
      logic              aneg;
      logic [TICK_W-1:0] tu;
      logic [TICK_W-1:0] u;
      logic [TICK_W-1:0] k;
   } side_type;

   typedef logic [LANES-1:0][NUM_W-1:0]  num_vec_type;
   typedef logic [LANES-1:0][LIMB_W-1:0] opnd_vec_type;
   typedef logic [LANES-1:0][REM_W-1:0]  rem_vec_type;

   typedef struct packed {
      logic              ovf;
      logic [QUO_W-1:0]  quo;
      logic [REM_W-1:0]  rem;
   } div_lane_type;

   typedef div_lane_type [LANES-1:0] div_vec_type;

   // magnitude and sign to signed 64-bit, clamped
   function automatic logic [DERIV_W-1:0] sat_deriv(input logic [QUO_W-1:0] quo,
                                                    input logic ovf,
                                                    input logic neg);
      logic [DERIV_W-1:0] res;
      if (neg) begin
         if (ovf || (quo > NEG_LIMIT)) res = NEG_LIMIT;
         else res = -quo;
      end else begin
         if (ovf || quo[QUO_W-1]) res = POS_LIMIT;
         else res = quo;
      end
      return res;
   endfunction

endpackage

/* rtl/quintic_trajectory_point.sv */
// ----------------------------------------------------------------------------
// quintic_trajectory_point
// Minimum-jerk quintic point (position, velocity, acceleration) for one axis.
// ----------------------------------------------------------------------------
// Usage: program start_pos, end_pos and duration over the csr_ port, then
// send query times on req_ (req_valid/req_stall). Each request yields one
// response on rsp_ with position (Q16.16) and velocity / acceleration (Q15.48).
// Times before zero return the start position, times past the duration the
// end position, both with zero derivatives.
// Throughput: one request per cycle while req_stall is low. The accepting edge
// loads the first of 80 register stages: input stage, six two-stage multiplier
// banks with the polynomial stage after the first, the 65-stage divider by T^5
// and the output register.
// After any register write the block stalls requests while a single 32x31
// multiplier builds T^5 limb by limb. Reset loads 0, 0 and 1, for which T^5
// is ready at once.
// When rsp_stall holds a waiting response the whole pipeline freezes and
// req_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quintic_trajectory_point import qtp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [TIME_W-1:0]  req_time_tick,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [POS_W-1:0]   rsp_position,
   output logic [DERIV_W-1:0] rsp_velocity,
   output logic [DERIV_W-1:0] rsp_acceleration,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   cfg_type cfg;
   logic    en;

   logic     s0_valid_ff;
   side_type s0_side_ff, s0_side_in;
   logic [TIME_W-1:0] twot;
   logic [TIME_W-1:0] kw;

   logic         m_valid [6];
   logic         m_valid_o [6];
   num_vec_type  m_a [6];
   opnd_vec_type m_b [6];
   num_vec_type  m_p [6];
   side_type     m_side_i [6];
   side_type     m_side_o [6];

   logic           p_valid_ff;
   side_type       p_side_ff;
   logic [P_W-1:0] p_ff, p_in, sq_tt, sq_tx, sq_xx;

   rem_vec_type div_num;
   logic        div_valid;
   div_vec_type div_lane;
   side_type    div_side;

   logic [POS_W-1:0]   off;
   logic [POS_W-1:0]   pos_in;
   logic [DERIV_W-1:0] vel_in, acc_in;
   logic               rsp_valid_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [DERIV_W-1:0] vel_ff, acc_ff;

   qtp_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en || cfg.busy;

   // stage 0: region, clamp and the u = T - t, k = |T - 2t| terms
   always_comb begin
      s0_side_in.below = req_time_tick[TIME_W-1];
      s0_side_in.above = !req_time_tick[TIME_W-1] &&
                         (req_time_tick[TICK_W-1:0] > cfg.duration);
      s0_side_in.tu    = (s0_side_in.below || s0_side_in.above) ? '0
                         : req_time_tick[TICK_W-1:0];
      s0_side_in.u     = cfg.duration - s0_side_in.tu;
      twot             = {s0_side_in.tu, 1'b0};
      if (twot <= {1'b0, cfg.duration}) begin
         kw              = {1'b0, cfg.duration} - twot;
         s0_side_in.aneg = cfg.dneg;
      end else begin
         kw              = twot - {1'b0, cfg.duration};
         s0_side_in.aneg = !cfg.dneg;
      end
      s0_side_in.k = kw[TICK_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (en) s0_valid_ff <= req_valid && !cfg.busy;
   end

   always_ff @(posedge clock) begin
      if (en) s0_side_ff <= s0_side_in;
   end

   // 10 T^2 - 15 t T + 6 t^2
   always_comb begin
      sq_tt = P_W'(m_p[0][LANE_POS][SQ_W-1:0]);
      sq_tx = P_W'(m_p[0][LANE_VEL][SQ_W-1:0]);
      sq_xx = P_W'(m_p[0][LANE_ACC][SQ_W-1:0]);
      p_in  = (sq_tt << 3) + (sq_tt << 1) + (sq_xx << 2) + (sq_xx << 1)
              + sq_tx - (sq_tx << 4);
   end

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else if (en) p_valid_ff <= m_valid_o[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff      <= p_in;
         p_side_ff <= m_side_o[0];
      end
   end

   // bank 0: T*T, t*T, t*t
   // banks 1..5: pos P*t*t*t*D, vel D*t*t*u*u*30, acc D*t*u*k*60
   always_comb begin
      m_valid[0]            = s0_valid_ff;
      m_side_i[0]           = s0_side_ff;
      m_a[0][LANE_POS]      = NUM_W'(cfg.duration);
      m_b[0][LANE_POS]      = LIMB_W'(cfg.duration);
      m_a[0][LANE_VEL]      = NUM_W'(s0_side_ff.tu);
      m_b[0][LANE_VEL]      = LIMB_W'(cfg.duration);
      m_a[0][LANE_ACC]      = NUM_W'(s0_side_ff.tu);
      m_b[0][LANE_ACC]      = LIMB_W'(s0_side_ff.tu);
      m_valid[1]          = p_valid_ff;
      m_side_i[1]         = p_side_ff;
      m_a[1][LANE_POS]    = NUM_W'(p_ff);
      m_a[1][LANE_VEL]    = NUM_W'(cfg.dmag);
      m_a[1][LANE_ACC]    = NUM_W'(cfg.dmag);
      m_b[1][LANE_POS]    = LIMB_W'(p_side_ff.tu);
      m_b[1][LANE_VEL]    = LIMB_W'(p_side_ff.tu);
      m_b[1][LANE_ACC]    = LIMB_W'(p_side_ff.tu);
      for (int j = 2; j < 6; j++) begin
         m_valid[j]  = m_valid_o[j-1];
         m_side_i[j] = m_side_o[j-1];
         m_a[j]      = m_p[j-1];
      end
      m_b[2][LANE_POS] = LIMB_W'(m_side_o[1].tu);
      m_b[2][LANE_VEL] = LIMB_W'(m_side_o[1].tu);
      m_b[2][LANE_ACC] = LIMB_W'(m_side_o[1].u);
      m_b[3][LANE_POS] = LIMB_W'(m_side_o[2].tu);
      m_b[3][LANE_VEL] = LIMB_W'(m_side_o[2].u);
      m_b[3][LANE_ACC] = LIMB_W'(m_side_o[2].k);
      m_b[4][LANE_POS] = cfg.dmag;
      m_b[4][LANE_VEL] = LIMB_W'(m_side_o[3].u);
      m_b[4][LANE_ACC] = UNIT_GAIN;
      m_b[5][LANE_POS] = UNIT_GAIN;
      m_b[5][LANE_VEL] = VEL_GAIN;
      m_b[5][LANE_ACC] = ACC_GAIN;
   end

   for (genvar g = 0; g < 6; g++) begin : g_bank
      qtp_mul u_mul (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (m_valid[g]),
         .in_a      (m_a[g]),
         .in_b      (m_b[g]),
         .in_side   (m_side_i[g]),
         .out_valid (m_valid_o[g]),
         .out_p     (m_p[g]),
         .out_side  (m_side_o[g])
      );
   end

   // velocity and acceleration carry the Q16 to Q48 scale
   always_comb begin
      div_num[LANE_POS] = REM_W'(m_p[5][LANE_POS]);
      div_num[LANE_VEL] = REM_W'(m_p[5][LANE_VEL]) << SCALE_SHIFT;
      div_num[LANE_ACC] = REM_W'(m_p[5][LANE_ACC]) << SCALE_SHIFT;
   end

   qtp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid_o[5]),
      .in_num    (div_num),
      .in_div    (cfg.t5),
      .in_side   (m_side_o[5]),
      .out_valid (div_valid),
      .out_lane  (div_lane),
      .out_side  (div_side)
   );

   always_comb begin
      off = div_lane[LANE_POS].quo[POS_W-1:0];
      if (div_side.below) begin
         pos_in = cfg.start_pos;
         vel_in = '0;
         acc_in = '0;
      end else if (div_side.above) begin
         pos_in = cfg.end_pos;
         vel_in = '0;
         acc_in = '0;
      end else begin
         pos_in = cfg.dneg ? cfg.start_pos - off : cfg.start_pos + off;
         vel_in = sat_deriv(div_lane[LANE_VEL].quo, div_lane[LANE_VEL].ovf, cfg.dneg);
         acc_in = sat_deriv(div_lane[LANE_ACC].quo, div_lane[LANE_ACC].ovf,
                            div_side.aneg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= div_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         acc_ff <= acc_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = pos_ff;
   assign rsp_velocity     = vel_ff;
   assign rsp_acceleration = acc_ff;

endmodule

/* rtl/qtp_cfg.sv */
// ----------------------------------------------------------------------------
// qtp_cfg
// Register file and sequencer that derives |D|, sign and T^5 after writes.
// ----------------------------------------------------------------------------
module qtp_cfg import qtp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [POS_W-1:0]      start_ff;
   logic [POS_W-1:0]      end_ff;
   logic [TICK_W-1:0]     dur_ff;
   cfg_state_type         state_ff, state_in;
   logic [LIMB_W-1:0]     acc_ff [T5_LIMBS];
   logic [LIMB_IDX_W-1:0] limb_ff;
   logic [PASS_W-1:0]     pass_ff;
   logic [LIMB_W-1:0]     carry_ff;
   logic [LIMB_W-1:0]     dmag_ff;
   logic                  dneg_ff;
   logic                  wr;
   logic [1:0]            reg_idx;
   logic [TICK_W-1:0]     dur_eff;
   logic [POS_W:0]        diff;
   logic [POS_W:0]        diff_mag;
   logic [PROD_W-1:0]     prod;
   logic                  busy;
   logic [T5_W-1:0]       t5;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign dur_eff    = (dur_ff == '0) ? TICK_W'(1) : dur_ff;
   assign diff       = {end_ff[POS_W-1], end_ff} - {start_ff[POS_W-1], start_ff};
   assign diff_mag   = diff[POS_W] ? -diff : diff;
   assign prod       = acc_ff[limb_ff] * dur_eff + carry_ff;

   always_comb begin
      case (reg_idx)
         REG_START:    csr_prdata = start_ff;
         REG_END:      csr_prdata = end_ff;
         REG_DURATION: csr_prdata = {1'b0, dur_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         dur_ff   <= TICK_W'(1);
      end else if (wr) begin
         case (reg_idx)
            REG_START:    start_ff <= csr_pwdata;
            REG_END:      end_ff   <= csr_pwdata;
            REG_DURATION: dur_ff   <= csr_pwdata[TICK_W-1:0];
            default:      ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CFG_IDLE: state_in = CFG_IDLE;
         CFG_LOAD: state_in = CFG_MUL;
         CFG_MUL: begin
            if ((limb_ff == LAST_LIMB) && (pass_ff == LAST_PASS)) state_in = CFG_IDLE;
         end
         default: state_in = CFG_IDLE;
      endcase
      if (wr) state_in = CFG_LOAD;
   end

   // outputs
   always_comb begin
      case (state_ff)
         CFG_IDLE: busy = 1'b0;
         default:  busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CFG_IDLE;
      else state_ff <= state_in;
   end

   // limb-serial multiply: acc *= T, four passes gives T^5
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < T5_LIMBS; i++) acc_ff[i] <= (i == 0) ? LIMB_W'(1) : '0;
         limb_ff  <= '0;
         pass_ff  <= '0;
         carry_ff <= '0;
         dmag_ff  <= '0;
         dneg_ff  <= 1'b0;
      end else begin
         case (state_ff)
            CFG_LOAD: begin
               for (int i = 0; i < T5_LIMBS; i++) begin
                  acc_ff[i] <= (i == 0) ? LIMB_W'(dur_eff) : '0;
               end
               limb_ff  <= '0;
               pass_ff  <= '0;
               carry_ff <= '0;
               dmag_ff  <= diff_mag[LIMB_W-1:0];
               dneg_ff  <= diff[POS_W];
            end
            CFG_MUL: begin
               acc_ff[limb_ff] <= prod[LIMB_W-1:0];
               if (limb_ff == LAST_LIMB) begin
                  limb_ff  <= '0;
                  carry_ff <= '0;
                  pass_ff  <= pass_ff + PASS_W'(1);
               end else begin
                  limb_ff  <= limb_ff + LIMB_IDX_W'(1);
                  carry_ff <= prod[PROD_W-1:LIMB_W];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < T5_LIMBS; i++) t5[LIMB_W*i +: LIMB_W] = acc_ff[i];
   end

   assign cfg.busy      = busy;
   assign cfg.dneg      = dneg_ff;
   assign cfg.dmag      = dmag_ff;
   assign cfg.start_pos = start_ff;
   assign cfg.end_pos   = end_ff;
   assign cfg.duration  = dur_eff;
   assign cfg.t5        = t5;

endmodule

/* rtl/qtp_mul.sv */
// ----------------------------------------------------------------------------
// qtp_mul
// Three-lane wide-by-32 multiplier: limb products, then one wide add.
// ----------------------------------------------------------------------------
module qtp_mul import qtp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  num_vec_type  in_a,
   input  opnd_vec_type in_b,
   input  side_type     in_side,
   output logic         out_valid,
   output num_vec_type  out_p,
   output side_type     out_side
);

   logic [LANES-1:0][NUM_LIMBS-1:0][PROD_W-1:0] pp_ff, pp_in;
   logic [LANES-1:0][REM_W-1:0] even_w, odd_w, total_w;
   num_vec_type sum_in, sum_ff;
   logic        valid1_ff, valid2_ff;
   side_type    side1_ff, side2_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int i = 0; i < NUM_LIMBS; i++) begin
            pp_in[l][i] = in_a[l][LIMB_W*i +: LIMB_W] * in_b[l];
         end
      end
   end

   // even limbs and odd limbs never overlap among themselves
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         even_w[l] = '0;
         odd_w[l]  = '0;
         for (int i = 0; i < NUM_LIMBS; i++) begin
            if ((i % 2) == 0) even_w[l][LIMB_W*i +: PROD_W] = pp_ff[l][i];
            else odd_w[l][LIMB_W*i +: PROD_W] = pp_ff[l][i];
         end
         total_w[l] = even_w[l] + odd_w[l];
         sum_in[l]  = total_w[l][NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff    <= pp_in;
         side1_ff <= in_side;
         sum_ff   <= sum_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_p     = sum_ff;
   assign out_side  = side2_ff;

endmodule

/* rtl/qtp_div.sv */
// ----------------------------------------------------------------------------
// qtp_div
// Pipelined restoring divider by T^5, three lanes, one quotient bit a stage.
// ----------------------------------------------------------------------------
module qtp_div import qtp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  rem_vec_type      in_num,
   input  logic [T5_W-1:0]  in_div,
   input  side_type         in_side,
   output logic             out_valid,
   output div_vec_type      out_lane,
   output side_type         out_side
);

   div_vec_type         lane_in [0:QUO_W];
   div_vec_type         lane_ff [0:QUO_W];
   side_type            side_ff [0:QUO_W];
   logic [QUO_W:0]      valid_ff;
   logic [REM_W-1:0]    shifted;
   logic                ge;

   always_comb begin
      shifted = '0;
      ge      = 1'b0;
      // first stage only flags quotients of 2^64 and more
      for (int l = 0; l < LANES; l++) begin
         lane_in[0][l].rem = in_num[l];
         lane_in[0][l].quo = '0;
         lane_in[0][l].ovf = in_num[l] >= {in_div, {QUO_W{1'b0}}};
      end
      for (int s = 1; s <= QUO_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            shifted = REM_W'(in_div) << (QUO_W - s);
            ge      = lane_ff[s-1][l].rem >= shifted;
            lane_in[s][l]                = lane_ff[s-1][l];
            lane_in[s][l].quo[QUO_W - s] = ge;
            if (ge) lane_in[s][l].rem = lane_ff[s-1][l].rem - shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[QUO_W-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 0; s <= QUO_W; s++) lane_ff[s] <= lane_in[s];
         for (int s = 1; s <= QUO_W; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_lane  = lane_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

/* rtl/qtp_checker.sv */
// ----------------------------------------------------------------------------
// qtp_checker
// Port-level checks for the quintic trajectory point block.
// ----------------------------------------------------------------------------
module qtp_checker import qtp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [POS_W-1:0]   rsp_position,
   input logic [DERIV_W-1:0] rsp_velocity,
   input logic [DERIV_W-1:0] rsp_acceleration,
   input logic               csr_psel,
   input logic               csr_penable,
   input logic               csr_pwrite
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position) &&
      $stable(rsp_velocity) && $stable(rsp_acceleration))
      else $error("stalled response changed");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while pipeline frozen");

   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> req_stall)
      else $error("request taken before T^5 rebuilt");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind quintic_trajectory_point qtp_checker u_checker (.*);

/* tb/quintic_trajectory_point_test.sv */
// ----------------------------------------------------------------------------
// quintic_trajectory_point_test
// Self-checking bench: programs start/end/duration over the csr_ port, sends
// query times on req_ under several idle/stall mixes and compares each rsp_
// point against an exact wide-integer minimum-jerk computation.
// ----------------------------------------------------------------------------
module quintic_trajectory_point_test;
   import qtp_pkg::*;

   typedef struct {
      logic [POS_W-1:0]   position;
      logic [DERIV_W-1:0] velocity;
      logic [DERIV_W-1:0] acceleration;
   } point_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [TIME_W-1:0]  req_time_tick = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [POS_W-1:0]   rsp_position;
   logic [DERIV_W-1:0] rsp_velocity;
   logic [DERIV_W-1:0] rsp_acceleration;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr = '0;
   logic [DATA_W-1:0]  csr_pwdata = '0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   quintic_trajectory_point DUT (.*);

   always #2 clock = ~clock;

   // shadow copy of the registers
   logic signed [63:0] cfg_start = 0;
   logic signed [63:0] cfg_end = 0;
   logic [TICK_W-1:0]  cfg_dur = 1;

   logic [TIME_W-1:0] time_q[$];
   point_type         point_q[$];
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   logic              hold_req = 1'b0;
   int                mismatches = 0;
   int                quiet_cycles = 0;

   function automatic logic [DERIV_W-1:0] clamp_deriv(logic [255:0] mag, logic neg);
      if (neg) begin
         if (mag > 256'h8000_0000_0000_0000) mag = 256'h8000_0000_0000_0000;
         return -mag[63:0];
      end
      if (mag > 256'h7FFF_FFFF_FFFF_FFFF) mag = 256'h7FFF_FFFF_FFFF_FFFF;
      return mag[63:0];
   endfunction

   function automatic point_type trajectory_point(logic [TIME_W-1:0] tick);
      point_type          pt;
      logic signed [63:0] t;
      logic [255:0]       bt, tu, u, k, dmag, t5, poly, x;
      logic signed [63:0] d, pos;
      logic               dneg, aneg;
      t = {{32{tick[31]}}, tick};
      bt = (cfg_dur == 0) ? 256'd1 : 256'(cfg_dur);
      d = cfg_end - cfg_start;
      dneg = d < 0;
      dmag = dneg ? 256'(-d) : 256'(d);
      if (t < 0 || t > $signed(bt[63:0])) begin
         pt.position = (t < 0) ? cfg_start[31:0] : cfg_end[31:0];
         pt.velocity = '0;
         pt.acceleration = '0;
         return pt;
      end
      tu = 256'(t);
      u = bt - tu;
      t5 = bt * bt * bt * bt * bt;
      poly = 10 * bt * bt + 6 * tu * tu - 15 * tu * bt;
      x = dmag * poly * tu * tu * tu / t5;
      pos = dneg ? cfg_start - $signed(x[63:0]) : cfg_start + $signed(x[63:0]);
      pt.position = pos[31:0];
      x = (dmag << 32) * 30 * tu * tu * u * u / t5;
      pt.velocity = clamp_deriv(x, dneg);
      if (2 * tu <= bt) begin
         k = bt - 2 * tu;
         aneg = dneg;
      end else begin
         k = 2 * tu - bt;
         aneg = !dneg;
      end
      x = (dmag << 32) * 60 * tu * u * k / t5;
      pt.acceleration = clamp_deriv(x, aneg);
      return pt;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (!hold_req && time_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_time_tick <= time_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // prediction on accepted requests, check on accepted responses
   always @(posedge clock) begin
      point_type want;
      if (!reset && req_valid && !req_stall)
         point_q.push_back(trajectory_point(req_time_tick));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (point_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response pos=%h", rsp_position);
         end else begin
            want = point_q.pop_front();
            if (rsp_position !== want.position || rsp_velocity !== want.velocity
                || rsp_acceleration !== want.acceleration) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp pos=%h vel=%h acc=%h got pos=%h vel=%h acc=%h",
                           want.position, want.velocity, want.acceleration,
                           rsp_position, rsp_velocity, rsp_acceleration);
            end
         end
      end
   end

   // watchdog on stuck traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (time_q.size() == 0 && point_q.size() == 0 && !req_valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("quintic_trajectory_point_test failed");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_START:    cfg_start = {{32{value[31]}}, value};
         REG_END:      cfg_end = {{32{value[31]}}, value};
         REG_DURATION: cfg_dur = value[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (time_q.size() == 0 && point_q.size() == 0 && !req_valid);
      repeat (120) @(posedge clock);
   endtask

   task automatic load_times(int count);
      logic [31:0] bt, v;
      int          r;
      bt = (cfg_dur == 0) ? 1 : cfg_dur;
      time_q.push_back(32'h8000_0000);
      time_q.push_back(32'hFFFF_FFFF);
      time_q.push_back(0);
      time_q.push_back(1);
      time_q.push_back(bt >> 1);
      time_q.push_back((bt >> 1) + 1);
      time_q.push_back(bt - 1);
      time_q.push_back(bt);
      time_q.push_back(32'h7FFF_FFFF);
      if (bt < 32'h7FFF_FFFF) time_q.push_back(bt + 1);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 70) v = $urandom_range(0, bt);
         else if (r < 85) v = $urandom | 32'h8000_0000;
         else if (bt < 32'h7FFF_FFFF) v = bt + $urandom_range(1, 32'h7FFF_FFFF - bt);
         else v = $urandom;
         time_q.push_back(v);
      end
   endtask

   initial begin
      logic [31:0] s, e, dv;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // reset settings first: zero travel, unit duration
      load_times(40);
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: begin s = 32'h8000_0000; e = 32'h7FFF_FFFF; dv = 1; end
            1: begin s = 32'h7FFF_FFFF; e = 32'h8000_0000; dv = 32'h7FFF_FFFF; end
            2: begin s = 32'h7FFF_FFFF; e = 32'h8000_0000; dv = 2; end
            3: begin s = $urandom; e = $urandom; dv = $urandom_range(1, 1000); end
            4: begin s = 32'h0001_0000; e = 32'hFFFF_0000; dv = $urandom_range(1, 50); end
            5: begin s = $urandom; e = $urandom; dv = $urandom_range(1, 32'h7FFF_FFFF); end
            6: begin s = 0; e = $urandom; dv = $urandom_range(1000, 100000); end
            default: begin s = $urandom; e = s; dv = $urandom_range(1, 200); end
         endcase
         csr_write(REG_START, s);
         csr_write(REG_END, e);
         csr_write(REG_DURATION, dv);
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 86; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 86; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         load_times(215);
         if (ph == 3) begin
            // hold off new requests until the pipeline has emptied
            wait (time_q.size() < 100);
            @(posedge clock);
            hold_req <= 1'b1;
            wait (point_q.size() == 0 && !req_valid);
            @(posedge clock);
            hold_req <= 1'b0;
         end
      end
      drain();
      if (mismatches == 0 && point_q.size() == 0) begin
         $display("quintic_trajectory_point_test passed");
      end else begin
         $display("quintic_trajectory_point_test failed");
      end
      $finish;
   end

endmodule
